FILE: design/cmu_tx_pkg.sv
// shared types and constants of the carrier modulated uart transmitter
`timescale 1ns / 1ps
package cmu_tx_pkg;

  localparam int BUFFER_DEPTH  = 16;
  localparam int TICKS_PER_BIT = 64;
  localparam int FRAME_BITS    = 10;
  localparam int STOP_BIT      = FRAME_BITS - 1;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 5;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 8;

  localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int TICK_W = $clog2(TICKS_PER_BIT);
  localparam int BIT_W  = $clog2(FRAME_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } op_t;

  // transmitter position within the buffer and within the frame
  typedef struct packed {
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] count;
    logic [BIT_W-1:0]   bit_no;
    logic [TICK_W-1:0]  tick;
  } tx_state_t;

endpackage

FILE: design/cmu_tx_buffer.sv
// byte buffer: one write port, one registered read port at the next send position
`timescale 1ns / 1ps
module cmu_tx_buffer (
  input  logic                         clk,
  input  logic                         we,
  input  logic [cmu_tx_pkg::IDX_W-1:0] waddr,
  input  logic [cmu_tx_pkg::BYTE_W-1:0] wdata,
  input  logic [cmu_tx_pkg::IDX_W-1:0] raddr,
  output logic [cmu_tx_pkg::BYTE_W-1:0] rdata
);
  import cmu_tx_pkg::*;

  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // write-through so a load to the slot being sent is seen at once
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/cmu_tx_frame.sv
// one tick of the frame sequencer: line level and advanced counters
`timescale 1ns / 1ps
module cmu_tx_frame (
  input  cmu_tx_pkg::tx_state_t          cur,
  input  logic [cmu_tx_pkg::BYTE_W-1:0]  tx_byte,
  output cmu_tx_pkg::tx_state_t          nxt,
  output logic                           line
);
  import cmu_tx_pkg::*;

  logic             bit_val;
  logic             odd_phase;
  logic [BIT_W-1:0] data_idx;

  assign data_idx = cur.bit_no - BIT_W'(1);
  // parity of bit_no * TICKS_PER_BIT + tick
  assign odd_phase = cur.tick[0] ^ (cur.bit_no[0] & TICKS_PER_BIT[0]);

  always_comb begin
    nxt     = cur;
    line    = 1'b0;
    bit_val = 1'b1;
    if (cur.pos != cur.count) begin
      if (cur.bit_no == '0) begin
        bit_val = 1'b0;
      end else if (cur.bit_no >= BIT_W'(STOP_BIT)) begin
        bit_val = 1'b1;
      end else begin
        bit_val = tx_byte[data_idx[2:0]];
      end
      line = !bit_val && odd_phase;
      if (cur.tick == TICK_W'(TICKS_PER_BIT - 1)) begin
        nxt.tick = '0;
        if (cur.bit_no == BIT_W'(STOP_BIT)) begin
          nxt.bit_no = '0;
          nxt.pos    = cur.pos + COUNT_W'(1);
        end else begin
          nxt.bit_no = cur.bit_no + BIT_W'(1);
        end
      end else begin
        nxt.tick = cur.tick + TICK_W'(1);
      end
    end
  end

endmodule

FILE: design/carrier_modulated_uart_tx.sv
// top level of the carrier modulated 8n1 uart transmitter
`timescale 1ns / 1ps
// output: the result of an accepted item is in the output register from the next cycle on
// throughput: one item per cycle; the state update and the result register
//   both close in the cycle of acceptance, and a new item is taken while the
//   previous result waits as long as the output is being drained
// reset: rst clears position, count, frame counters, line level and output valid;
//   buffer contents are undefined until loaded
module carrier_modulated_uart_tx (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // operation[1:0], slot_index[5:2], data_byte[13:6], byte_count[18:14], zeros
  input  logic [cmu_tx_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // line_out[0], busy_res[1], position[6:2], zero[7]
  output logic [cmu_tx_pkg::OUT_W-1:0]   m_axis_tdata
);
  import cmu_tx_pkg::*;

  // input item fields
  op_t                in_op;
  logic [SLOT_W-1:0]  in_slot;
  logic [BYTE_W-1:0]  in_byte;
  logic [COUNT_W-1:0] in_count;
  logic [COUNT_W-1:0] sat_count;

  assign in_op    = op_t'(s_axis_tdata[1:0]);
  assign in_slot  = s_axis_tdata[5:2];
  assign in_byte  = s_axis_tdata[13:6];
  assign in_count = s_axis_tdata[18:14];

  // start count saturates at the buffer depth
  assign sat_count = (in_count > COUNT_W'(BUFFER_DEPTH)) ? COUNT_W'(BUFFER_DEPTH) : in_count;

  // transmitter state
  tx_state_t st;
  tx_state_t st_next;
  tx_state_t tick_st;
  logic      line_level;
  logic      line_level_next;
  logic      tick_line;

  logic              accept;
  logic              buf_we;
  logic [IDX_W-1:0]  buf_raddr;
  logic [BYTE_W-1:0] cur_byte;
  logic              busy_next;

  // output register frees the input side whenever it is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // buffer read is registered, so it is addressed by the position of the next cycle
  assign buf_raddr = rst ? '0 : st_next.pos[IDX_W-1:0];

  cmu_tx_buffer u_buffer (
    .clk   (clk),
    .we    (buf_we),
    .waddr (in_slot[IDX_W-1:0]),
    .wdata (in_byte),
    .raddr (buf_raddr),
    .rdata (cur_byte)
  );

  cmu_tx_frame u_frame (
    .cur     (st),
    .tx_byte (cur_byte),
    .nxt     (tick_st),
    .line    (tick_line)
  );

  always_comb begin
    st_next         = st;
    line_level_next = line_level;
    buf_we          = 1'b0;
    if (accept) begin
      case (in_op)
        OP_TICK: begin
          st_next         = tick_st;
          line_level_next = tick_line;
        end
        OP_LOAD: begin
          // loads to slots past the buffer are dropped
          buf_we = (32'(in_slot) < BUFFER_DEPTH);
        end
        OP_START: begin
          // frame counters are not reset, so the first frame may start mid-way
          st_next.pos   = '0;
          st_next.count = sat_count;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy_next = (st_next.pos != st_next.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '0;
      line_level    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      st         <= st_next;
      line_level <= line_level_next;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result payload, written with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {1'b0, st_next.pos, busy_next, line_level_next};
    end
  end

  // position never runs past the count it is chasing
  a_pos_le_count: assert property (@(posedge clk) disable iff (rst)
    st.pos <= st.count)
    else $error("send position past send count");

  // frame counters stay inside one frame
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    (st.bit_no <= BIT_W'(STOP_BIT)) && (32'(st.tick) < TICKS_PER_BIT))
    else $error("frame counters out of range");

  // a tick while idle drives the line low
  a_idle_tick_low: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_op == OP_TICK) && (st.pos == st.count)) |=> !line_level)
    else $error("idle tick left the line high");

  // a pending result that is not taken blocks new items
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("item accepted over a pending result");

endmodule
